// ===== src/msbp_pkg.sv =====
`default_nettype none

package msbp_pkg;

   // Configuration register and value field widths
   localparam int CFG_BITS       = 6;
   localparam int VALUE_BITS     = 32;
   localparam logic [CFG_BITS-1:0] WIDTH_RESET = 6'd8;

   // Result queue geometry
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

   // Words produced by one packed value: a completed word and/or a flushed tail
   typedef struct packed {
      logic full_valid;
      logic full_final;
      logic full_invalid;
      logic flush_valid;
      logic flush_invalid;
   } emit_type;

endpackage

`default_nettype wire

// ===== src/msbp_pack.sv =====
`default_nettype none

module msbp_pack #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [msbp_pkg::CFG_BITS-1:0] value_width,
   input  wire logic [msbp_pkg::VALUE_BITS-1:0] value,
   input  wire logic                          final_value,
   output msbp_pkg::emit_type                 emit,
   output logic [WORD_BITS-1:0]               full_word,
   output logic [WORD_BITS-1:0]               flush_word
);

   localparam int NB  = $clog2(WORD_BITS);
   localparam int AW  = $clog2(WORD_BITS + 1);
   localparam int CAP = (WORD_BITS < msbp_pkg::VALUE_BITS) ? WORD_BITS : msbp_pkg::VALUE_BITS;
   localparam logic [msbp_pkg::CFG_BITS-1:0] CAP_CFG = msbp_pkg::CFG_BITS'(CAP);
   localparam logic [AW-1:0] WORD_AW = AW'(WORD_BITS);

   logic [WORD_BITS-1:0] partial_ff, partial_in;
   logic [NB-1:0]        filled_ff, filled_in;
   logic                 overwide_ff, overwide_in;

   logic [msbp_pkg::CFG_BITS-1:0]   w_cfg;
   logic [msbp_pkg::VALUE_BITS-1:0] vmask;
   logic [msbp_pkg::VALUE_BITS-1:0] v_masked;
   logic [WORD_BITS+msbp_pkg::VALUE_BITS-1:0] v_ext;
   logic [WORD_BITS-1:0] v_word;
   logic [AW-1:0]        w_aw;
   logic [AW-1:0]        room;
   logic [AW-1:0]        rest;
   logic [NB-1:0]        n_new;
   logic                 ov_now;
   logic [WORD_BITS-1:0] part_new;

   always_comb begin
      // clamp the width into 1..CAP
      w_cfg = value_width;
      if (w_cfg == '0) begin
         w_cfg = msbp_pkg::CFG_BITS'(1);
      end
      if (w_cfg > CAP_CFG) begin
         w_cfg = CAP_CFG;
      end
      vmask    = {msbp_pkg::VALUE_BITS{1'b1}} >> (msbp_pkg::CFG_BITS'(msbp_pkg::VALUE_BITS) - w_cfg);
      v_masked = value & vmask;
      v_ext    = {{WORD_BITS{1'b0}}, v_masked};
      v_word   = v_ext[WORD_BITS-1:0];
      w_aw     = AW'(w_cfg);
      ov_now   = overwide_ff | ((value & ~vmask) != '0);
      room     = WORD_AW - AW'(filled_ff);
      rest     = '0;

      emit       = '0;
      full_word  = '0;
      flush_word = '0;
      part_new   = partial_ff;
      n_new      = filled_ff;

      if (w_aw < room) begin
         part_new = partial_ff | (v_word << (room - w_aw));
         n_new    = NB'(AW'(filled_ff) + w_aw);
      end else if (w_aw == room) begin
         full_word         = partial_ff | v_word;
         emit.full_valid   = 1'b1;
         emit.full_final   = final_value;
         emit.full_invalid = final_value & ov_now;
         part_new          = '0;
         n_new             = '0;
      end else begin
         // straddle: high bits close this word, low bits open the next
         rest            = w_aw - room;
         full_word       = partial_ff | (v_word >> rest);
         emit.full_valid = 1'b1;
         part_new        = v_word << (WORD_AW - rest);
         n_new           = NB'(rest);
      end

      flush_word         = part_new;
      emit.flush_valid   = final_value & (n_new != '0);
      emit.flush_invalid = ov_now;

      partial_in  = part_new;
      filled_in   = n_new;
      overwide_in = ov_now;
      if (final_value) begin
         partial_in  = '0;
         filled_in   = '0;
         overwide_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         filled_ff   <= '0;
         overwide_ff <= 1'b0;
      end else if (advance) begin
         partial_ff  <= partial_in;
         filled_ff   <= filled_in;
         overwide_ff <= overwide_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/msb_first_bit_packer.sv =====
// MSB-first bit packer.
// Values arrive on the req_ channel (req_valid / req_stall) and are packed
// most-significant-bit first, with no gaps, into WORD_BITS-bit words sent on
// the rsp_ channel (rsp_valid / rsp_stall). A transfer happens on a clock
// edge where valid is high and stall is low.
// csr_ writes set the packing width (1..32, at most WORD_BITS; 0 acts as
// 1); csr_ready is always high. Write the width only while the block is
// idle. One value is taken every cycle while req_stall is low. Each value
// yields zero, one or two words: a completed word, and on a final value
// the zero-padded tail word. A word passes from the input register
// through the pack logic into a 4-entry result queue before it leaves.
// The input register advances only while the queue has room for two
// words, so a stalled receiver backs up into req_stall after the queue
// fills; nothing is dropped and a stalled rsp_ payload holds.
// run_invalid is set on the final word when any value of the run had bits
// above the width. Reset (synchronous) empties the queue and the input
// register, clears the partial word, and sets the width to 8.
`default_nettype none

module msb_first_bit_packer #(
   parameter int WORD_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [msbp_pkg::VALUE_BITS-1:0]   req_value,
   input  wire logic                              req_final_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [WORD_BITS-1:0]                   rsp_packed_word,
   output logic                                   rsp_final_word,
   output logic                                   rsp_run_invalid,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [msbp_pkg::CFG_BITS-1:0]     csr_value_width
);

   localparam int PB = msbp_pkg::QUEUE_PTR_BITS;
   localparam int QD = msbp_pkg::QUEUE_DEPTH;

   // configuration
   logic [msbp_pkg::CFG_BITS-1:0] width_ff;

   // input register
   logic                            in_valid_ff, in_valid_in;
   logic [msbp_pkg::VALUE_BITS-1:0] in_value_ff;
   logic                            in_final_ff;
   logic                            req_take;
   logic                            advance;

   // pack stage outputs
   msbp_pkg::emit_type   emit;
   logic [WORD_BITS-1:0] full_word;
   logic [WORD_BITS-1:0] flush_word;

   // result queue
   logic [WORD_BITS-1:0] q_word_ff    [QD];
   logic                 q_final_ff   [QD];
   logic                 q_invalid_ff [QD];
   logic [PB-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PB:0]          count_ff, count_in;
   logic                 pop;
   logic                 push_first, push_second;
   logic [WORD_BITS-1:0] first_word;
   logic                 first_final, first_invalid;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= msbp_pkg::WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_value_width;
      end
   end

   // Advance the input register only when the queue can absorb two words.
   assign advance   = in_valid_ff && (count_ff <= (PB+1)'(QD - 2));
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold payload until the next transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_value_ff <= req_value;
         in_final_ff <= req_final_value;
      end
   end

   msbp_pack #(
      .WORD_BITS (WORD_BITS)
   ) u_pack (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .value_width (width_ff),
      .value       (in_value_ff),
      .final_value (in_final_ff),
      .emit        (emit),
      .full_word   (full_word),
      .flush_word  (flush_word)
   );

   // Compact the completed word and the tail word into consecutive slots.
   always_comb begin
      push_first    = advance && (emit.full_valid || emit.flush_valid);
      push_second   = advance && emit.full_valid && emit.flush_valid;
      first_word    = emit.full_valid ? full_word : flush_word;
      first_final   = emit.full_valid ? emit.full_final : 1'b1;
      first_invalid = emit.full_valid ? emit.full_invalid : emit.flush_invalid;
   end

   assign rsp_valid       = (count_ff != '0);
   assign pop             = rsp_valid && !rsp_stall;
   assign rsp_packed_word = q_word_ff[rd_ptr_ff];
   assign rsp_final_word  = q_final_ff[rd_ptr_ff];
   assign rsp_run_invalid = q_invalid_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PB'(push_first) + PB'(push_second);
      rd_ptr_in = rd_ptr_ff + PB'(pop);
      count_in  = count_ff + (PB+1)'(push_first) + (PB+1)'(push_second) - (PB+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         q_word_ff[wr_ptr_ff]    <= first_word;
         q_final_ff[wr_ptr_ff]   <= first_final;
         q_invalid_ff[wr_ptr_ff] <= first_invalid;
      end
      if (push_second) begin
         q_word_ff[wr_ptr_ff + PB'(1)]    <= flush_word;
         q_final_ff[wr_ptr_ff + PB'(1)]   <= 1'b1;
         q_invalid_ff[wr_ptr_ff + PB'(1)] <= emit.flush_invalid;
      end
   end

endmodule

`default_nettype wire
